FILE: src/rtti_pkg.sv
package rtti_pkg;

    localparam int OUT_BITS = 64;
    localparam int VALUE_BITS_DEFAULT = 64;
    localparam int CP_BITS = 21;
    localparam int RADIX_BITS = 6;

    localparam logic [RADIX_BITS-1:0] RESET_RADIX = 6'd10;

    localparam logic [CP_BITS-1:0] CHAR_MINUS = 21'h2D;
    localparam logic [CP_BITS-1:0] CHAR_PLUS = 21'h2B;
    localparam logic [CP_BITS-1:0] CHAR_0 = 21'h30;
    localparam logic [CP_BITS-1:0] CHAR_9 = 21'h39;
    localparam logic [CP_BITS-1:0] CHAR_UA = 21'h41;
    localparam logic [CP_BITS-1:0] CHAR_UZ = 21'h5A;
    localparam logic [CP_BITS-1:0] CHAR_LA = 21'h61;
    localparam logic [CP_BITS-1:0] CHAR_LZ = 21'h7A;
    localparam logic [RADIX_BITS-1:0] LETTER_BASE = 6'd10;

    typedef struct packed {
        logic [CP_BITS-1:0] code_point;
        logic [RADIX_BITS-1:0] radix;
        logic last;
        logic empty_req;
    } item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic valid_res;
    } result_t;

    typedef struct packed {
        logic ok;
        logic [RADIX_BITS-1:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [CP_BITS-1:0] c);
        digit_t d;
        logic [CP_BITS-1:0] off;
        d.ok = 1'b0;
        d.val = '0;
        off = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            off = c - CHAR_0;
            d.ok = 1'b1;
            d.val = off[RADIX_BITS-1:0];
        end
        else if (c >= CHAR_UA && c <= CHAR_UZ)
        begin
            off = c - CHAR_UA;
            d.ok = 1'b1;
            d.val = off[RADIX_BITS-1:0] + LETTER_BASE;
        end
        else if (c >= CHAR_LA && c <= CHAR_LZ)
        begin
            off = c - CHAR_LA;
            d.ok = 1'b1;
            d.val = off[RADIX_BITS-1:0] + LETTER_BASE;
        end
        return d;
    endfunction

endpackage

FILE: src/rtti_acc.sv
module rtti_acc #(
    parameter int VALUE_BITS = rtti_pkg::VALUE_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  rtti_pkg::item_t  item,
    output logic             produce,
    output rtti_pkg::result_t result
);

    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic at_first_reg, at_first_next;
    logic negative_reg, negative_next;
    logic bad_reg, bad_next;
    logic [rtti_pkg::RADIX_BITS-1:0] radix_reg, radix_next;

    logic [VALUE_BITS-1:0] acc0;
    logic neg0;
    logic bad0;
    logic [rtti_pkg::RADIX_BITS-1:0] rad;
    logic is_sign;
    rtti_pkg::digit_t dig;
    logic [VALUE_BITS+rtti_pkg::RADIX_BITS-1:0] prod;
    logic [VALUE_BITS-1:0] acc1;
    logic neg1;
    logic bad1;
    logic signed [VALUE_BITS-1:0] signed_val;

    always_comb
    begin
        acc0 = at_first_reg ? '0 : acc_reg;
        neg0 = at_first_reg ? 1'b0 : negative_reg;
        bad0 = at_first_reg ? 1'b0 : bad_reg;
        rad = at_first_reg ? item.radix : radix_reg;
        is_sign = at_first_reg
            && (item.code_point == rtti_pkg::CHAR_MINUS || item.code_point == rtti_pkg::CHAR_PLUS);
        dig = rtti_pkg::digit_of(item.code_point);
        prod = (VALUE_BITS + rtti_pkg::RADIX_BITS)'(acc0)
             * (VALUE_BITS + rtti_pkg::RADIX_BITS)'(rad);

        acc1 = acc0;
        neg1 = neg0;
        bad1 = bad0;
        if (is_sign)
        begin
            if (item.last)
                bad1 = 1'b1;
            else
                neg1 = (item.code_point == rtti_pkg::CHAR_MINUS);
        end
        else if (!dig.ok || dig.val >= rad)
        begin
            bad1 = 1'b1;
        end
        else
        begin
            acc1 = prod[VALUE_BITS-1:0] + VALUE_BITS'(dig.val);
        end

        signed_val = neg1 ? (~acc1 + VALUE_BITS'(1)) : acc1;

        produce = item.empty_req | item.last;
        result.value = '0;
        result.valid_res = 1'b0;
        if (!item.empty_req && !bad1)
        begin
            result.value = rtti_pkg::OUT_BITS'(signed_val);
            result.valid_res = 1'b1;
        end

        acc_next = acc1;
        negative_next = neg1;
        bad_next = bad1;
        radix_next = rad;
        at_first_next = 1'b0;
        if (item.empty_req)
        begin
            radix_next = radix_reg;
        end
        if (produce)
        begin
            acc_next = '0;
            negative_next = 1'b0;
            bad_next = 1'b0;
            at_first_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            at_first_reg <= 1'b1;
            negative_reg <= 1'b0;
            bad_reg <= 1'b0;
            radix_reg <= rtti_pkg::RESET_RADIX;
        end
        else if (advance)
        begin
            acc_reg <= acc_next;
            at_first_reg <= at_first_next;
            negative_reg <= negative_next;
            bad_reg <= bad_next;
            radix_reg <= radix_next;
        end
    end

endmodule

FILE: src/radix_text_to_integer.sv
// A beat is held in the input register, and a string's result in the output register.
// Throughput: one beat per cycle, unless a string end waits behind an untaken result;
// the single multiply-add by the radix sets the cycle. The two registers part the two
// sides, so a beat is taken while a result waits, unless the held beat ends a string.
// Reset empties both registers and clears the string state; the held radix returns to ten.
module radix_text_to_integer #(
    parameter int VALUE_BITS = rtti_pkg::VALUE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // code_point[20:0], radix[26:21], zero fill
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,  // empty_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // value[63:0]
    output logic        m_axis_tuser   // valid_res
);

    logic in_valid_reg, in_valid_next;
    rtti_pkg::item_t in_item_reg;
    logic out_valid_reg, out_valid_next;
    rtti_pkg::result_t out_reg;
    rtti_pkg::result_t result;
    logic produce;
    logic advance;

    rtti_acc #(
        .VALUE_BITS(VALUE_BITS)
    ) u_acc (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .item(in_item_reg),
        .produce(produce),
        .result(result)
    );

    always_comb
    begin
        advance = in_valid_reg && (!produce || !out_valid_reg || m_axis_tready);
        s_axis_tready = !in_valid_reg || advance;
        in_valid_next = (s_axis_tvalid && s_axis_tready) || (in_valid_reg && !advance);
        if (advance && produce)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.code_point <= s_axis_tdata[20:0];
            in_item_reg.radix <= s_axis_tdata[26:21];
            in_item_reg.last <= s_axis_tlast;
            in_item_reg.empty_req <= s_axis_tuser;
        end
        if (advance && produce)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg.value;
    assign m_axis_tuser = out_reg.valid_res;

endmodule
